// ===== rtl/baro_pressure_temp_compensation_core_assert.svh =====
// Assertion macros for the barometric compensation core checker.
// Expects clk and arst_n in scope at the point of use.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_CORE_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_CORE_ASSERT_SVH

// same-cycle implication
`define BPTC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define BPTC_ASSERT_LAT(label, ante, lat, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##lat (cons)) \
		else $error(msg);

`endif

// ===== rtl/bptc_pkg.sv =====
// Package for the barometric compensation core.
// Calibration register indexes, word types and fixed temperature thresholds.
package bptc_pkg;

	localparam int CAL_COUNT = 6;
	localparam int CAL_IDX_W = 3;
	localparam int TEMP_W    = 21;

	typedef logic [15:0] cal_word_t;

	typedef enum logic [CAL_IDX_W-1:0] {
		REG_PSENS    = 3'd0,
		REG_POFF     = 3'd1,
		REG_SENS_TC  = 3'd2,
		REG_OFF_TC   = 3'd3,
		REG_REF_TEMP = 3'd4,
		REG_TEMP_TC  = 3'd5
	} cal_reg_t;

	// 20.00 and -15.00 degrees in hundredths
	localparam logic signed [TEMP_W-1:0] TEMP_REF = 21'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_LOW = -21'sd1500;

endpackage

// ===== rtl/baro_pressure_temp_compensation_core.sv =====
// Barometric pressure/temperature compensation core, second-order correction.
// Depends on bptc_pkg.
//
// Usage:
//  - Input: raw_pressure and raw_temperature are taken at a rising edge where
//    start is high and busy is low. busy is always low: a new pair may be
//    started in every cycle.
//  - Result: pressure_out and temperature_out are valid for exactly one cycle
//    while done is high, in the order the pairs were started. The receiver
//    cannot stall; a result not taken in its cycle is gone.
//  - Pipeline: a started pair passes registered stages s1 to s9; done and
//    the result come from s9. Throughput is one pair per cycle, set by the
//    nine-stage pipeline, whose multipliers sit in stages s2, s4 and s7.
//  - Calibration: six 16-bit words written over cfg_valid/cfg_ready with
//    cfg_index 0..5; other indexes are ignored. cfg_ready is always high.
//    Write only while no transaction is in flight.
//  - Reset (arst_n low) clears the calibration words and drops every
//    transaction in the pipeline; no done follows for them.
module baro_pressure_temp_compensation_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [23:0]                        raw_pressure,
	input  logic [23:0]                        raw_temperature,
	output logic                               done,
	output logic signed [31:0]                 pressure_out,
	output logic signed [31:0]                 temperature_out,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bptc_pkg::CAL_IDX_W-1:0]     cfg_index,
	input  bptc_pkg::cal_word_t                cfg_data
);
	import bptc_pkg::*;

	cal_word_t cal_q [CAL_COUNT];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	logic [23:0]              d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;
	logic signed [24:0]       dt_s1;
	logic signed [41:0]       pt_s2, po_s2, ps_s2;
	logic signed [49:0]       pdd_s2;
	logic signed [TEMP_W-1:0] temp_s3, temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;
	logic signed [39:0]       off_s3, off_s4, off_s5, off_s6, off_s7, off_s8;
	logic signed [39:0]       sens_s3, sens_s4, sens_s5, sens_s6;
	logic [18:0]              t2_s3, t2_s4;
	logic [35:0]              sqw_s4, sqc_s4;
	logic                     lt_ref_s4, lt_low_s4;
	logic [39:0]              off2_s5, sens2_s5;
	logic [43:0]              pl_s7;
	logic signed [44:0]       ph_s7;
	logic [63:0]              prod_s8;
	logic signed [31:0]       pres_s9, temp_s9;

	logic signed [TEMP_W-1:0] dw, dc;
	logic signed [41:0]       sqw_full, sqc_full;
	logic [39:0]              w5, c7, c11, off2_c, sens2_c;
	logic [43:0]              x_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAL_COUNT; i++) begin
				cal_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PSENS:    cal_q[REG_PSENS]    <= cfg_data;
				REG_POFF:     cal_q[REG_POFF]     <= cfg_data;
				REG_SENS_TC:  cal_q[REG_SENS_TC]  <= cfg_data;
				REG_OFF_TC:   cal_q[REG_OFF_TC]   <= cfg_data;
				REG_REF_TEMP: cal_q[REG_REF_TEMP] <= cfg_data;
				REG_TEMP_TC:  cal_q[REG_TEMP_TC]  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	always_comb begin
		dw       = temp_s3 - TEMP_REF;
		dc       = temp_s3 - TEMP_LOW;
		sqw_full = dw * dw;
		sqc_full = dc * dc;
		w5       = {4'd0, sqw_s4} + {2'd0, sqw_s4, 2'd0};
		c7       = {1'd0, sqc_s4, 3'd0} - {4'd0, sqc_s4};
		c11      = {1'd0, sqc_s4, 3'd0} + {3'd0, sqc_s4, 1'd0} + {4'd0, sqc_s4};
		off2_c   = {1'b0, w5[39:1]} + (lt_low_s4 ? c7 : 40'd0);
		sens2_c  = {2'b0, w5[39:2]} + (lt_low_s4 ? {1'b0, c11[39:1]} : 40'd0);
		x_c      = {prod_s8[63], prod_s8[63:21]} - {{4{off_s8[39]}}, off_s8};
	end

	always_ff @(posedge clk) begin
		// s1: temperature difference
		d1_s1 <= raw_pressure;
		dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal_q[REG_REF_TEMP], 8'd0});

		// s2: first-order products
		d1_s2  <= d1_s1;
		pt_s2  <= dt_s1 * $signed({1'b0, cal_q[REG_TEMP_TC]});
		po_s2  <= dt_s1 * $signed({1'b0, cal_q[REG_OFF_TC]});
		ps_s2  <= dt_s1 * $signed({1'b0, cal_q[REG_SENS_TC]});
		pdd_s2 <= dt_s1 * dt_s1;

		// s3: TEMP, OFF, SENS, T2
		d1_s3   <= d1_s2;
		temp_s3 <= {{2{pt_s2[41]}}, pt_s2[41:23]} + TEMP_REF;
		off_s3  <= $signed({8'd0, cal_q[REG_POFF], 16'd0})
			+ $signed({{5{po_s2[41]}}, po_s2[41:7]});
		sens_s3 <= $signed({9'd0, cal_q[REG_PSENS], 15'd0})
			+ $signed({{6{ps_s2[41]}}, ps_s2[41:8]});
		t2_s3   <= pdd_s2[49:31];

		// s4: squares for the second-order terms
		d1_s4     <= d1_s3;
		temp_s4   <= temp_s3;
		off_s4    <= off_s3;
		sens_s4   <= sens_s3;
		t2_s4     <= t2_s3;
		sqw_s4    <= sqw_full[35:0];
		sqc_s4    <= sqc_full[35:0];
		lt_ref_s4 <= temp_s3 < TEMP_REF;
		lt_low_s4 <= temp_s3 < TEMP_LOW;

		// s5: OFF2, SENS2, corrected TEMP
		d1_s5    <= d1_s4;
		off_s5   <= off_s4;
		sens_s5  <= sens_s4;
		off2_s5  <= lt_ref_s4 ? off2_c : 40'd0;
		sens2_s5 <= lt_ref_s4 ? sens2_c : 40'd0;
		temp_s5  <= lt_ref_s4 ? temp_s4 - $signed({2'b0, t2_s4}) : temp_s4;

		// s6: corrected OFF and SENS
		d1_s6   <= d1_s5;
		temp_s6 <= temp_s5;
		off_s6  <= off_s5 - $signed(off2_s5);
		sens_s6 <= sens_s5 - $signed(sens2_s5);

		// s7: raw_pressure * SENS in two partial products
		temp_s7 <= temp_s6;
		off_s7  <= off_s6;
		pl_s7   <= d1_s6 * sens_s6[19:0];
		ph_s7   <= $signed({1'b0, d1_s6}) * $signed(sens_s6[39:20]);

		// s8: partial product sum
		temp_s8 <= temp_s7;
		off_s8  <= off_s7;
		prod_s8 <= {ph_s7[43:0], 20'd0} + {20'd0, pl_s7};

		// s9: pressure and result register
		pres_s9 <= {{3{x_c[43]}}, x_c[43:15]};
		temp_s9 <= {{(32-TEMP_W){temp_s8[TEMP_W-1]}}, temp_s8};
	end

	assign done            = v_s9;
	assign pressure_out    = pres_s9;
	assign temperature_out = temp_s9;

endmodule

// ===== rtl/bptc_checker.sv =====
// Port-level checker for the barometric compensation core, with its bind.
// Depends on baro_pressure_temp_compensation_core_assert.svh.
`include "baro_pressure_temp_compensation_core_assert.svh"

module bptc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] pressure_out,
	input logic [31:0] temperature_out
);

	`BPTC_ASSERT_LAT(a_start_gives_done, start && !busy, 9, done, "accepted transaction gave no result")
	`BPTC_ASSERT_NOW(a_done_has_start, done, $past(start && !busy, 9), "result without transaction")
	`BPTC_ASSERT_NOW(a_temp_range, done, temperature_out[31:20] == 12'h000 || temperature_out[31:20] == 12'hfff, "temperature out of range")
	`BPTC_ASSERT_NOW(a_pres_range, done, pressure_out[31:27] == 5'h00 || pressure_out[31:27] == 5'h1f, "pressure out of range")

endmodule

bind baro_pressure_temp_compensation_core bptc_checker u_bptc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.pressure_out    (pressure_out),
	.temperature_out (temperature_out)
);
